// ===== design/gbca_pkg.sv =====
package gbca_pkg;

	localparam int ROW_W   = 6;
	localparam int COL_W   = 6;
	localparam int LABEL_W = 16;
	localparam int RANGE_W = 7;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 32;

	localparam logic [RANGE_W-1:0] COVER_RESET = 7'd16;
	localparam int MIN_COVER = 2;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_UP    = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef enum logic [7:0] {
		ST_CLR   = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_POP   = 8'b0000_0100,
		ST_LOAD  = 8'b0000_1000,
		ST_NB    = 8'b0001_0000,
		ST_CHK   = 8'b0010_0000,
		ST_FLUSH = 8'b0100_0000,
		ST_SWEEP = 8'b1000_0000
	} state_t;

endpackage

// ===== design/gbca_step.sv =====
module gbca_step #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64,
	localparam int RW = $clog2(GRID_ROWS),
	localparam int CW = $clog2(GRID_COLS)
) (
	input  logic [RW-1:0]   row,
	input  logic [CW-1:0]   col,
	input  gbca_pkg::dir_t  dir,
	output logic [RW-1:0]   row_n,
	output logic [CW-1:0]   col_n,
	output logic            ok
);
	import gbca_pkg::*;

	always_comb begin
		row_n = row;
		col_n = col;
		ok    = 1'b0;
		case (dir)
			DIR_RIGHT: begin
				col_n = col + CW'(1);
				ok    = (col != CW'(GRID_COLS - 1));
			end
			DIR_DOWN: begin
				row_n = row + RW'(1);
				ok    = (row != RW'(GRID_ROWS - 1));
			end
			DIR_UP: begin
				row_n = row - RW'(1);
				ok    = (row != '0);
			end
			DIR_LEFT: begin
				col_n = col - CW'(1);
				ok    = (col != '0);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/grid_bfs_cover_area.sv =====
// channel | dir | beat fields (low bit up)                      | handshake
// s_*     | in  | tdata: center_row, center_col, label          | tvalid/tready
// m_*     | out | tdata: cell_row, cell_col, cell_label; tlast  | tvalid/tready
// cfg_*   | in  | cover_range                                   | cfg_wen only
// After reset a clearing pass writes all 2^(clog2(GRID_ROWS)+clog2(GRID_COLS)) addresses
// (4096 at 64x64) of the visited map to zero; s_tready stays low until it ends.
// After an item is accepted, s_tready stays low until it is done; output stalls can
// lengthen the fill. Each neighbor check has one address/read state and one decide
// state on the shared step unit and the registered-read visited map, and a closing
// sweep sets the touched visited bits back to zero at the end.
// A full output register stalls the fill when a new cell is found.
module grid_bfs_cover_area #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64,
	parameter int MAX_COVER = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [gbca_pkg::S_DATA_W-1:0]   s_tdata,   // center_row, center_col, label
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gbca_pkg::M_DATA_W-1:0]   m_tdata,   // cell_row, cell_col, cell_label
	output logic                            m_tlast,
	input  logic                            cfg_wen,
	input  logic [gbca_pkg::RANGE_W-1:0]    cfg_wdata
);
	import gbca_pkg::*;

	localparam int RW   = $clog2(GRID_ROWS);
	localparam int CW   = $clog2(GRID_COLS);
	localparam int AW   = RW + CW;
	localparam int QW   = $clog2(MAX_COVER);
	localparam int CNTW = $clog2(MAX_COVER + 1);

	state_t state_q;
	logic [RANGE_W-1:0] cover_q;
	logic [CNTW-1:0]    limit_q;
	logic [CNTW-1:0]    count_q;
	logic [CNTW-1:0]    head_q;
	logic [CNTW-1:0]    sw_q;
	logic               swv_s1;
	logic [AW-1:0]      clr_q;
	dir_t               dir_q;
	logic [LABEL_W-1:0] label_q;
	logic [RW-1:0]      cur_row_q, nb_row_q, pend_row_q;
	logic [CW-1:0]      cur_col_q, nb_col_q, pend_col_q;
	logic               nb_ok_q;

	logic               vis_mem [2**AW];
	logic               vis_rd_q;
	logic               vis_we, vis_wdata;
	logic [AW-1:0]      vis_waddr, vis_raddr;

	logic [AW-1:0]      q_mem [MAX_COVER];
	logic [AW-1:0]      q_rd_q;
	logic               q_we;
	logic [QW-1:0]      q_widx, q_raddr;
	logic [AW-1:0]      q_wdata;

	logic [RW-1:0]      st_row;
	logic [CW-1:0]      st_col;
	logic               st_ok;

	logic [RW+ROW_W-1:0] cr_ext;
	logic [CW+COL_W-1:0] cc_ext;
	logic [RW-1:0]       c_row;
	logic [CW-1:0]       c_col;
	logic [CNTW-1:0]     lim_d;
	logic [CNTW-1:0]     cnt_nxt;
	logic                in_acc, out_free, new_cell, take_cell, load_out, out_last;
	logic [RW+ROW_W-1:0] prow_ext;
	logic [CW+COL_W-1:0] pcol_ext;

	gbca_step #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_step (
		.row   (cur_row_q),
		.col   (cur_col_q),
		.dir   (dir_q),
		.row_n (st_row),
		.col_n (st_col),
		.ok    (st_ok)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign cnt_nxt  = count_q + CNTW'(1);
	assign new_cell = nb_ok_q && !vis_rd_q;
	assign take_cell = (state_q == ST_CHK) && new_cell && out_free;
	assign load_out = take_cell || ((state_q == ST_FLUSH) && out_free);
	assign out_last = (state_q == ST_FLUSH);

	assign cr_ext = {{RW{1'b0}}, s_tdata[ROW_W-1:0]};
	assign cc_ext = {{CW{1'b0}}, s_tdata[ROW_W+COL_W-1:ROW_W]};
	assign c_row  = (cr_ext >= (RW+ROW_W)'(GRID_ROWS)) ? RW'(GRID_ROWS - 1) : cr_ext[RW-1:0];
	assign c_col  = (cc_ext >= (CW+COL_W)'(GRID_COLS)) ? CW'(GRID_COLS - 1) : cc_ext[CW-1:0];

	always_comb begin
		if (cover_q > RANGE_W'(MAX_COVER)) begin
			lim_d = CNTW'(MAX_COVER);
		end else if (cover_q < RANGE_W'(MIN_COVER)) begin
			lim_d = CNTW'(MIN_COVER);
		end else begin
			lim_d = cover_q[CNTW-1:0];
		end
	end

	always_comb begin
		vis_we    = 1'b0;
		vis_wdata = 1'b0;
		vis_waddr = {nb_row_q, nb_col_q};
		q_we      = 1'b0;
		q_widx    = count_q[QW-1:0];
		q_wdata   = {nb_row_q, nb_col_q};
		q_raddr   = head_q[QW-1:0];
		vis_raddr = {nb_row_q, nb_col_q};
		case (state_q)
			ST_CLR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
			end
			ST_IDLE: begin
				vis_we    = in_acc;
				vis_wdata = 1'b1;
				vis_waddr = {c_row, c_col};
				q_we      = in_acc;
				q_widx    = '0;
				q_wdata   = {c_row, c_col};
			end
			ST_NB: begin
				vis_raddr = {st_row, st_col};
			end
			ST_CHK: begin
				vis_we    = take_cell;
				vis_wdata = 1'b1;
				q_we      = take_cell;
			end
			ST_SWEEP: begin
				q_raddr   = sw_q[QW-1:0];
				vis_we    = swv_s1;
				vis_waddr = q_rd_q;
			end
			default: begin
				vis_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		vis_rd_q <= vis_mem[vis_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_widx] <= q_wdata;
		end
		q_rd_q <= q_mem[q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cover_q <= COVER_RESET;
		end else if (cfg_wen) begin
			cover_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			count_q <= '0;
			head_q  <= '0;
			sw_q    <= '0;
			swv_s1  <= 1'b0;
			dir_q   <= DIR_RIGHT;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						count_q <= CNTW'(1);
						head_q  <= '0;
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (head_q == count_q) begin
						state_q <= ST_FLUSH;
					end else begin
						head_q  <= head_q + CNTW'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					dir_q   <= DIR_RIGHT;
					state_q <= ST_NB;
				end
				ST_NB: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (!new_cell || take_cell) begin
						if (take_cell) begin
							count_q <= cnt_nxt;
						end
						if (take_cell && (cnt_nxt >= limit_q)) begin
							state_q <= ST_FLUSH;
						end else if (dir_q == DIR_LEFT) begin
							state_q <= ST_POP;
						end else begin
							dir_q   <= dir_t'(dir_q + 2'd1);
							state_q <= ST_NB;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						sw_q    <= '0;
						swv_s1  <= 1'b0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					swv_s1 <= (sw_q != count_q);
					if (sw_q != count_q) begin
						sw_q <= sw_q + CNTW'(1);
					end else if (!swv_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			label_q    <= s_tdata[ROW_W+COL_W+LABEL_W-1:ROW_W+COL_W];
			limit_q    <= lim_d;
			pend_row_q <= c_row;
			pend_col_q <= c_col;
		end
		if (state_q == ST_LOAD) begin
			cur_row_q <= q_rd_q[AW-1:CW];
			cur_col_q <= q_rd_q[CW-1:0];
		end
		if (state_q == ST_NB) begin
			nb_row_q <= st_row;
			nb_col_q <= st_col;
			nb_ok_q  <= st_ok;
		end
		if (take_cell) begin
			pend_row_q <= nb_row_q;
			pend_col_q <= nb_col_q;
		end
	end

	assign prow_ext = {{ROW_W{1'b0}}, pend_row_q};
	assign pcol_ext = {{COL_W{1'b0}}, pend_col_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= {(M_DATA_W-ROW_W-COL_W-LABEL_W)'(0), label_q,
				pcol_ext[COL_W-1:0], prow_ext[ROW_W-1:0]};
			m_tlast <= out_last;
		end
	end

endmodule

// ===== design/gbca_check.sv =====
module gbca_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [gbca_pkg::M_DATA_W-1:0]   m_tdata,
	input logic                            m_tlast
);
	import gbca_pkg::*;

	localparam int USED_W = ROW_W + COL_W + LABEL_W;

	// output beat holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// busy right after an item is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accept");

	// a non-final beat means the fill is still running
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("idle with item unfinished");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_DATA_W-1:USED_W] == '0))
		else $error("pad bits set");

endmodule

bind grid_bfs_cover_area gbca_check u_gbca_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
